// File: rtl/dtfp_pkg.sv
`default_nettype none

package dtfp_pkg;

    // Defaults for the top level parameters
    localparam int DEF_VALUE_BITS    = 64;
    localparam int DEF_POSITION_BITS = 12;
    localparam int DEF_MAX_PLACES    = 31;

    // Fixed port widths
    localparam int CHAR_W      = 8;
    localparam int VALUE_W     = 64;
    localparam int STATUS_W    = 2;
    localparam int END_W       = 12;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int PLACES_W    = 5;
    localparam int RWIDTH_W    = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FRACTION_PLACES   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRACTION_ENABLE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIGNED_MODE       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESULT_WIDTH      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WHOLE_STRING_ONLY = 3'd4;

    // Result width codes
    localparam logic [RWIDTH_W-1:0] RW_8  = 2'd0;
    localparam logic [RWIDTH_W-1:0] RW_16 = 2'd1;
    localparam logic [RWIDTH_W-1:0] RW_32 = 2'd2;
    localparam logic [RWIDTH_W-1:0] RW_64 = 2'd3;

    // Characters
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_FIVE  = 8'h35;
    localparam logic [CHAR_W-1:0] CH_SIX   = 8'h36;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [STATUS_W-1:0] {
        PS_OK       = 2'd0,
        PS_SYNTAX   = 2'd1,
        PS_OVERFLOW = 2'd2
    } parse_status_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_MAC,
        ACC_PAD,
        ACC_BUMP
    } acc_op_t;

    typedef struct packed {
        logic [PLACES_W-1:0] fraction_places;
        logic                fraction_enable;
        logic                signed_mode;
        logic [RWIDTH_W-1:0] result_width;
        logic                whole_string_only;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic    char_load;
        acc_op_t acc_op;
        logic    places_load;
        logic    places_dec;
        logic    neg_set;
        logic    syntax_set;
        logic    end_mark;
        logic    trail_check;
        logic    idx_inc;
        logic    finish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_digit;
        logic is_blank;
        logic is_sign;
        logic is_point;
        logic is_nul;
        logic is_five;
        logic is_high;
        logic is_zero_digit;
        logic places_nz;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// File: rtl/dtfp_char_if.sv
`default_nettype none

interface dtfp_char_if;
    import dtfp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

`default_nettype wire

// File: rtl/dtfp_cfg_if.sv
`default_nettype none

interface dtfp_cfg_if;
    import dtfp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/dtfp_result_if.sv
`default_nettype none

interface dtfp_result_if;
    import dtfp_pkg::*;

    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  value_bits;
    logic [STATUS_W-1:0] parse_status;
    logic [END_W-1:0]    end_position;

    modport source (output valid, output value_bits, output parse_status,
                    output end_position, input ready);
    modport sink (input valid, input value_bits, input parse_status,
                  input end_position, output ready);
endinterface

`default_nettype wire

// File: rtl/dtfp_ctrl.sv
`default_nettype none

module dtfp_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire dtfp_pkg::cfg_t  cfg,
    input  wire dtfp_pkg::stat_t stat,
    input  wire logic           in_valid,
    output logic                in_ready,
    output dtfp_pkg::cmd_t       cmd
);
    import dtfp_pkg::*;

    typedef enum logic [1:0] {
        ST_WAIT,
        ST_EXEC,
        ST_PAD,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_POSTSIGN,
        PH_INT,
        PH_FRAC,
        PH_ROUND5,
        PH_SKIP,
        PH_TAIL
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    always_comb
    begin
        logic char_done;
        char_done  = 1'b0;
        cmd        = '0;
        cmd.acc_op = ACC_HOLD;
        state_next = state_reg;
        phase_next = phase_reg;
        in_ready   = (state_reg == ST_WAIT);

        unique case (state_reg)
            ST_WAIT:
            begin
                if (in_valid)
                begin
                    cmd.char_load = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                char_done = 1'b1;
                unique case (phase_reg) inside
                    PH_LEAD, PH_POSTSIGN:
                    begin
                        if (stat.is_blank)
                        begin
                        end
                        else if (stat.is_digit)
                        begin
                            cmd.acc_op      = ACC_LOAD;
                            cmd.places_load = 1'b1;
                            phase_next      = PH_INT;
                        end
                        else if (phase_reg == PH_LEAD && cfg.signed_mode && stat.is_sign)
                        begin
                            cmd.neg_set = 1'b1;
                            phase_next  = PH_POSTSIGN;
                        end
                        else
                        begin
                            cmd.syntax_set = 1'b1;
                            cmd.end_mark   = 1'b1;
                            phase_next     = PH_TAIL;
                        end
                    end
                    PH_INT:
                    begin
                        if (stat.is_digit)
                        begin
                            cmd.acc_op = ACC_MAC;
                        end
                        else if (!cfg.fraction_enable)
                        begin
                            cmd.end_mark = 1'b1;
                            phase_next   = PH_TAIL;
                        end
                        else if (stat.is_point)
                        begin
                            phase_next = PH_FRAC;
                        end
                        else
                        begin
                            char_done  = 1'b0;
                            state_next = ST_PAD;
                        end
                    end
                    PH_FRAC:
                    begin
                        if (stat.places_nz && stat.is_digit)
                        begin
                            cmd.acc_op     = ACC_MAC;
                            cmd.places_dec = 1'b1;
                        end
                        else
                        begin
                            char_done  = 1'b0;
                            state_next = ST_PAD;
                        end
                    end
                    PH_ROUND5:
                    begin
                        if (stat.is_zero_digit)
                        begin
                        end
                        else if (stat.is_digit)
                        begin
                            cmd.acc_op = ACC_BUMP;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            cmd.end_mark = 1'b1;
                            phase_next   = PH_TAIL;
                        end
                    end
                    PH_SKIP:
                    begin
                        if (!stat.is_digit)
                        begin
                            cmd.end_mark = 1'b1;
                            phase_next   = PH_TAIL;
                        end
                    end
                    PH_TAIL:
                    begin
                        cmd.trail_check = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_LEAD;
                    end
                endcase
            end
            ST_PAD:
            begin
                if (stat.places_nz)
                begin
                    cmd.acc_op     = ACC_PAD;
                    cmd.places_dec = 1'b1;
                end
                else
                begin
                    // padding done, this character now decides rounding
                    char_done = 1'b1;
                    if (stat.is_high)
                    begin
                        cmd.acc_op = ACC_BUMP;
                        phase_next = PH_SKIP;
                    end
                    else if (stat.is_five)
                    begin
                        phase_next = PH_ROUND5;
                    end
                    else if (stat.is_digit)
                    begin
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        cmd.end_mark = 1'b1;
                        phase_next   = PH_TAIL;
                    end
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    phase_next = PH_LEAD;
                    state_next = ST_WAIT;
                end
            end
        endcase

        if (char_done)
        begin
            if (stat.is_nul)
            begin
                state_next = ST_FINISH;
            end
            else
            begin
                cmd.idx_inc = 1'b1;
                state_next  = ST_WAIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WAIT;
            phase_reg <= PH_LEAD;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    a_tail_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TAIL && state_reg != ST_FINISH) |=> phase_reg == PH_TAIL)
        else $error("number end reopened before string terminator");

    a_load_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.acc_op == ACC_LOAD) |-> (phase_reg == PH_LEAD || phase_reg == PH_POSTSIGN))
        else $error("first digit load outside leading scan");

    a_finish_on_nul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> stat.is_nul)
        else $error("result formed without a string terminator");

endmodule

`default_nettype wire

// File: rtl/dtfp_dp.sv
`default_nettype none

module dtfp_dp #(
    parameter int VALUE_BITS    = dtfp_pkg::DEF_VALUE_BITS,
    parameter int POSITION_BITS = dtfp_pkg::DEF_POSITION_BITS,
    parameter int MAX_PLACES    = dtfp_pkg::DEF_MAX_PLACES
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dtfp_pkg::cmd_t                 cmd,
    input  wire dtfp_pkg::cfg_t                 cfg,
    input  wire logic [dtfp_pkg::CHAR_W-1:0]    char_code,
    output dtfp_pkg::stat_t                     stat,
    output logic                                out_valid,
    input  wire logic                          out_ready,
    output logic [dtfp_pkg::VALUE_W-1:0]        value_bits,
    output logic [dtfp_pkg::STATUS_W-1:0]       parse_status,
    output logic [dtfp_pkg::END_W-1:0]          end_position
);
    import dtfp_pkg::*;

    localparam int AW  = VALUE_BITS;
    localparam int MW  = VALUE_BITS + 4;
    localparam int PW  = POSITION_BITS;
    localparam int PLW = (MAX_PLACES > 0) ? $clog2(MAX_PLACES + 1) : 1;
    localparam logic [6:0]    VB7  = 7'(VALUE_BITS);

    logic [CHAR_W-1:0]   char_reg, char_next;
    logic [AW-1:0]       acc_reg, acc_next;
    logic                ovf_reg, ovf_next;
    logic                neg_reg, neg_next;
    logic                syntax_reg, syntax_next;
    logic                trail_reg, trail_next;
    logic [PLW-1:0]      places_reg, places_next;
    logic [PW-1:0]       idx_reg, idx_next;
    logic [PW-1:0]       end_reg, end_next;
    logic                out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]  out_value_reg, out_value_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [END_W-1:0]    out_end_reg, out_end_next;

    logic          is_digit, is_ws, is_nul;
    logic [3:0]    digit_val;
    logic [MW-1:0] wide;
    logic          wide_ovf;
    logic [6:0]    e_bits;
    logic [AW-1:0] umax, smag, spos;
    logic          range_bad;
    logic [VALUE_W-1:0] acc_ext;

    // character classes
    always_comb
    begin
        is_digit  = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
        is_nul    = (char_reg == CH_NUL);
        is_ws     = (char_reg == CH_SPACE) || (char_reg == CH_TAB) || (char_reg == CH_CR)
                 || (char_reg == CH_LF) || (char_reg == CH_VT) || (char_reg == CH_FF);
        digit_val = char_reg[3:0];

        stat.is_digit      = is_digit;
        stat.is_blank      = (char_reg == CH_SPACE) || (char_reg == CH_TAB);
        stat.is_sign       = (char_reg == CH_PLUS) || (char_reg == CH_MINUS);
        stat.is_point      = (char_reg == CH_POINT);
        stat.is_nul        = is_nul;
        stat.is_five       = (char_reg == CH_FIVE);
        stat.is_high       = (char_reg >= CH_SIX) && (char_reg <= CH_NINE);
        stat.is_zero_digit = (char_reg == CH_ZERO);
        stat.places_nz     = |places_reg;
        stat.out_free      = !out_valid_reg || out_ready;
    end

    // x10 + digit as x8 + x2, shared by digit accumulation and place padding
    always_comb
    begin
        wide     = (MW'(acc_reg) << 3) + (MW'(acc_reg) << 1)
                 + ((cmd.acc_op == ACC_PAD) ? MW'(0) : MW'(digit_val));
        wide_ovf = |wide[MW-1:AW];
    end

    // range check for the end of string
    always_comb
    begin
        case (cfg.result_width)
            RW_8:    e_bits = 7'd8;
            RW_16:   e_bits = 7'd16;
            RW_32:   e_bits = 7'd32;
            default: e_bits = 7'd64;
        endcase
        if (e_bits > VB7)
        begin
            e_bits = VB7;
        end
        umax = {AW{1'b1}} >> (VB7 - e_bits);
        smag = AW'(1) << (e_bits - 7'd1);
        spos = smag - AW'(1);
        if (cfg.signed_mode && neg_reg)
        begin
            range_bad = acc_reg > smag;
        end
        else if (cfg.signed_mode)
        begin
            range_bad = acc_reg > spos;
        end
        else
        begin
            range_bad = acc_reg > umax;
        end
        acc_ext = VALUE_W'(acc_reg);
    end

    always_comb
    begin
        char_next       = cmd.char_load ? char_code : char_reg;
        acc_next        = acc_reg;
        ovf_next        = ovf_reg;
        neg_next        = neg_reg;
        syntax_next     = syntax_reg;
        trail_next      = trail_reg;
        places_next     = places_reg;
        idx_next        = idx_reg;
        end_next        = end_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_end_next    = out_end_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        case (cmd.acc_op)
            ACC_LOAD:
            begin
                acc_next = AW'(digit_val);
            end
            ACC_MAC:
            begin
                // digits after an overflow are ignored
                if (!ovf_reg)
                begin
                    if (wide_ovf)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = wide[AW-1:0];
                    end
                end
            end
            ACC_PAD:
            begin
                if (wide_ovf)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    acc_next = wide[AW-1:0];
                end
            end
            ACC_BUMP:
            begin
                if (&acc_reg)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    acc_next = acc_reg + AW'(1);
                end
            end
            default:
            begin
            end
        endcase

        if (cmd.places_load)
        begin
            places_next = (int'(cfg.fraction_places) > MAX_PLACES)
                        ? PLW'(MAX_PLACES) : PLW'(cfg.fraction_places);
        end
        else if (cmd.places_dec)
        begin
            places_next = places_reg - PLW'(1);
        end

        if (cmd.neg_set)
        begin
            neg_next = (char_reg == CH_MINUS);
        end
        if (cmd.syntax_set)
        begin
            syntax_next = 1'b1;
        end
        if (cmd.end_mark)
        begin
            end_next = idx_reg;
        end
        if ((cmd.end_mark || cmd.trail_check) && !is_ws && !is_nul)
        begin
            trail_next = 1'b1;
        end
        if (cmd.idx_inc && (idx_reg != {PW{1'b1}}))
        begin
            idx_next = idx_reg + PW'(1);
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            out_end_next   = END_W'(end_reg);
            out_value_next = '0;
            if (syntax_reg)
            begin
                out_status_next = PS_SYNTAX;
            end
            else if (ovf_reg || range_bad)
            begin
                out_status_next = PS_OVERFLOW;
            end
            else if (trail_reg && cfg.whole_string_only)
            begin
                out_status_next = PS_SYNTAX;
            end
            else
            begin
                out_status_next = PS_OK;
                out_value_next  = neg_reg ? (~acc_ext + VALUE_W'(1)) : acc_ext;
            end
            acc_next    = '0;
            ovf_next    = 1'b0;
            neg_next    = 1'b0;
            syntax_next = 1'b0;
            trail_next  = 1'b0;
            places_next = '0;
            idx_next    = '0;
            end_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            syntax_reg    <= 1'b0;
            trail_reg     <= 1'b0;
            places_reg    <= '0;
            idx_reg       <= '0;
            end_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            neg_reg       <= neg_next;
            syntax_reg    <= syntax_next;
            trail_reg     <= trail_next;
            places_reg    <= places_next;
            idx_reg       <= idx_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg       <= char_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_end_reg    <= out_end_next;
    end

    assign out_valid    = out_valid_reg;
    assign value_bits   = out_value_reg;
    assign parse_status = out_status_reg;
    assign end_position = out_end_reg;

    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != PS_OK) |-> out_value_reg == '0)
        else $error("failed parse carries a non-zero value");

    a_places_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(places_reg) <= MAX_PLACES)
        else $error("places counter above clamp");

    a_idx_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg == {PW{1'b1}} && !cmd.finish) |=> idx_reg == {PW{1'b1}})
        else $error("character index wrapped");

endmodule

`default_nettype wire

// File: rtl/decimal_text_to_fixed_point_unit.sv
`default_nettype none

// ASCII decimal string to fixed-point integer converter.
// chars: one character per transfer; a zero byte ends the string and yields
//   exactly one transfer on results. Other characters yield nothing.
// cfg: register writes (index, data), always ready; registers take effect on
//   the next character processed.
// results: value_bits, parse_status (ok / syntax / overflow), end_position.
// Flow: each character is accepted in ST_WAIT, then takes one x10-and-add
//   step in ST_EXEC. A non-digit that closes a number in fraction mode then
//   passes through ST_PAD, which pads one decimal place per step, since
//   padding reuses the same x10 unit, and then decides rounding. The
//   terminator passes through ST_FINISH, which forms the result in the
//   output register once any padding is done.
// The result sits in an output register: characters of the next string are
//   accepted while it waits, and only the next terminator stalls until the
//   previous result has been taken.
// Reset: registers return to 0 places, fraction on, signed, 64-bit range,
//   trailing text allowed; string state is cleared and no result is pending.
module decimal_text_to_fixed_point_unit #(
    parameter int VALUE_BITS    = dtfp_pkg::DEF_VALUE_BITS,
    parameter int POSITION_BITS = dtfp_pkg::DEF_POSITION_BITS,
    parameter int MAX_PLACES    = dtfp_pkg::DEF_MAX_PLACES
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dtfp_char_if.sink   chars,
    dtfp_cfg_if.sink    cfg,
    dtfp_result_if.source results
);
    import dtfp_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    cmd_t  cmd;
    stat_t stat;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_FRACTION_PLACES:   cfg_next.fraction_places   = cfg.data[PLACES_W-1:0];
                CFG_FRACTION_ENABLE:   cfg_next.fraction_enable   = cfg.data[0];
                CFG_SIGNED_MODE:       cfg_next.signed_mode       = cfg.data[0];
                CFG_RESULT_WIDTH:      cfg_next.result_width      = cfg.data[RWIDTH_W-1:0];
                CFG_WHOLE_STRING_ONLY: cfg_next.whole_string_only = cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fraction_places   <= '0;
            cfg_reg.fraction_enable   <= 1'b1;
            cfg_reg.signed_mode       <= 1'b1;
            cfg_reg.result_width      <= RW_64;
            cfg_reg.whole_string_only <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg.ready = 1'b1;

    dtfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .stat     (stat),
        .in_valid (chars.valid),
        .in_ready (chars.ready),
        .cmd      (cmd)
    );

    dtfp_dp #(
        .VALUE_BITS    (VALUE_BITS),
        .POSITION_BITS (POSITION_BITS),
        .MAX_PLACES    (MAX_PLACES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg          (cfg_reg),
        .char_code    (chars.char_code),
        .stat         (stat),
        .out_valid    (results.valid),
        .out_ready    (results.ready),
        .value_bits   (results.value_bits),
        .parse_status (results.parse_status),
        .end_position (results.end_position)
    );

endmodule

`default_nettype wire

// File: tb/sv/decimal_parse_checker.sv
module decimal_parse_checker (
    input  logic   clk,
    input  logic   rst_n,
    dtfp_char_if   chars,
    dtfp_cfg_if    cfg,
    dtfp_result_if results,
    output int     fail_count,
    output int     pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import dtfp_pkg::*;

    typedef enum logic [2:0] {
        SCAN_LEAD,
        SCAN_POSTSIGN,
        SCAN_INT,
        SCAN_FRAC,
        SCAN_ROUND5,
        SCAN_SKIP,
        SCAN_TAIL
    } scan_phase_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        parse_status_t      status;
        logic [END_W-1:0]   end_pos;
    } parse_result_t;

    localparam logic [VALUE_W-1:0] ACC_MAX       = '1;
    localparam logic [VALUE_W-1:0] ACC_MAX_DIV10 = ACC_MAX / 10;
    localparam logic [VALUE_W-1:0] ACC_MAX_MOD10 = ACC_MAX % 10;
    localparam logic [END_W-1:0]   INDEX_MAX     = '1;

    cfg_t               settings;
    scan_phase_t        phase;
    logic [VALUE_W-1:0] acc;
    logic               overflow;
    logic               negative;
    logic               syntax_err;
    logic               trailing_junk;
    logic [5:0]         places_left;
    logic [END_W-1:0]   char_idx;
    logic [END_W-1:0]   number_end;
    parse_result_t      awaited_results[$];

    function automatic logic is_digit(logic [CHAR_W-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // characters allowed after the number when whole_string_only is set
    function automatic logic may_trail(logic [CHAR_W-1:0] c);
        return c inside {CH_NUL, CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_VT, CH_FF};
    endfunction

    function automatic void restart_string();
        phase         = SCAN_LEAD;
        acc           = '0;
        overflow      = 1'b0;
        negative      = 1'b0;
        syntax_err    = 1'b0;
        trailing_junk = 1'b0;
        places_left   = '0;
        char_idx      = '0;
        number_end    = '0;
    endfunction

    function automatic void add_digit(logic [CHAR_W-1:0] c);
        logic [VALUE_W-1:0] d;
        d = VALUE_W'(c - CH_ZERO);
        if (overflow)
            return;
        if (acc > ACC_MAX_DIV10 || (acc == ACC_MAX_DIV10 && d > ACC_MAX_MOD10))
            overflow = 1'b1;
        else
            acc = acc * 10 + d;
    endfunction

    function automatic void bump();
        if (acc >= ACC_MAX)
            overflow = 1'b1;
        else
            acc = acc + 1;
    endfunction

    function automatic void pad_places();
        while (places_left != 0)
        begin
            if (acc > ACC_MAX_DIV10)
                overflow = 1'b1;
            else
                acc = acc * 10;
            places_left = places_left - 6'd1;
        end
    endfunction

    function automatic void close_number(logic [CHAR_W-1:0] c);
        number_end = char_idx;
        phase      = SCAN_TAIL;
        if (!may_trail(c))
            trailing_junk = 1'b1;
    endfunction

    // first digit past the kept places decides rounding
    function automatic void round_on(logic [CHAR_W-1:0] c);
        if (c >= CH_SIX && c <= CH_NINE)
        begin
            bump();
            phase = SCAN_SKIP;
        end
        else if (c == CH_FIVE)
            phase = SCAN_ROUND5;
        else if (is_digit(c))
            phase = SCAN_SKIP;
        else
            close_number(c);
    endfunction

    function automatic void scan_char(logic [CHAR_W-1:0] c);
        case (phase)
            SCAN_LEAD, SCAN_POSTSIGN:
            begin
                if (c != CH_SPACE && c != CH_TAB)
                begin
                    if (is_digit(c))
                    begin
                        places_left = 6'(settings.fraction_places);
                        acc         = '0;
                        add_digit(c);
                        phase       = SCAN_INT;
                    end
                    else if (phase == SCAN_LEAD && settings.signed_mode &&
                             (c == CH_MINUS || c == CH_PLUS))
                    begin
                        negative = (c == CH_MINUS);
                        phase    = SCAN_POSTSIGN;
                    end
                    else
                    begin
                        syntax_err = 1'b1;
                        close_number(c);
                    end
                end
            end
            SCAN_INT:
            begin
                if (is_digit(c))
                    add_digit(c);
                else if (!settings.fraction_enable)
                    close_number(c);
                else if (c == CH_POINT)
                    phase = SCAN_FRAC;
                else
                begin
                    pad_places();
                    round_on(c);
                end
            end
            SCAN_FRAC:
            begin
                if (places_left != 0 && is_digit(c))
                begin
                    add_digit(c);
                    places_left = places_left - 6'd1;
                end
                else
                begin
                    pad_places();
                    round_on(c);
                end
            end
            SCAN_ROUND5:
            begin
                // a five rounds up only once a later non-zero digit shows
                if (c != CH_ZERO)
                begin
                    if (is_digit(c))
                    begin
                        bump();
                        phase = SCAN_SKIP;
                    end
                    else
                        close_number(c);
                end
            end
            SCAN_SKIP:
            begin
                if (!is_digit(c))
                    close_number(c);
            end
            default:
                close_number(c);
        endcase
    endfunction

    function automatic void finish_string();
        int unsigned   e;
        logic          range_bad;
        parse_result_t r;
        e = 8 << settings.result_width;
        if (settings.signed_mode && negative)
            range_bad = acc > (64'd1 << (e - 1));
        else if (settings.signed_mode)
            range_bad = acc > ((64'd1 << (e - 1)) - 64'd1);
        else
            range_bad = acc > (ACC_MAX >> (64 - e));
        r.value   = '0;
        r.end_pos = number_end;
        if (syntax_err)
            r.status = PS_SYNTAX;
        else if (overflow || range_bad)
            r.status = PS_OVERFLOW;
        else if (trailing_junk && settings.whole_string_only)
            r.status = PS_SYNTAX;
        else
        begin
            r.status = PS_OK;
            r.value  = negative ? '0 - acc : acc;
        end
        awaited_results.push_back(r);
    endfunction

    function automatic void parse_char(logic [CHAR_W-1:0] c);
        if (phase == SCAN_TAIL)
        begin
            if (!may_trail(c))
                trailing_junk = 1'b1;
        end
        else
            scan_char(c);
        if (c != CH_NUL)
        begin
            if (char_idx != INDEX_MAX)
                char_idx = char_idx + END_W'(1);
        end
        else
        begin
            finish_string();
            restart_string();
        end
    endfunction

    always @(posedge clk)
    begin : watch
        parse_result_t want;
        if (!rst_n)
        begin
            settings.fraction_places   = '0;
            settings.fraction_enable   = 1'b1;
            settings.signed_mode       = 1'b1;
            settings.result_width      = RW_64;
            settings.whole_string_only = 1'b0;
            restart_string();
            awaited_results.delete();
        end
        else
        begin
            // results first: a terminator transfer never pairs with its own result
            if (results.valid && results.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with none expected: value %h status %0d end %0d",
                             $time, results.value_bits, results.parse_status,
                             results.end_position);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (results.value_bits !== want.value)
                    begin
                        fail_count++;
                        $display("%0t: value_bits expected %h, got %h",
                                 $time, want.value, results.value_bits);
                    end
                    if (results.parse_status !== want.status)
                    begin
                        fail_count++;
                        $display("%0t: parse_status expected %0d, got %0d",
                                 $time, want.status, results.parse_status);
                    end
                    if (results.end_position !== want.end_pos)
                    begin
                        fail_count++;
                        $display("%0t: end_position expected %0d, got %0d",
                                 $time, want.end_pos, results.end_position);
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_FRACTION_PLACES:   settings.fraction_places = cfg.data[PLACES_W-1:0];
                    CFG_FRACTION_ENABLE:   settings.fraction_enable = cfg.data[0];
                    CFG_SIGNED_MODE:       settings.signed_mode = cfg.data[0];
                    CFG_RESULT_WIDTH:      settings.result_width = cfg.data[RWIDTH_W-1:0];
                    CFG_WHOLE_STRING_ONLY: settings.whole_string_only = cfg.data[0];
                    default: ;
                endcase
            end
            if (chars.valid && chars.ready)
                parse_char(chars.char_code);
        end
        pending_count = awaited_results.size();
    end

endmodule

// File: tb/sv/tb_decimal_text_to_fixed_point_unit.sv
module tb_decimal_text_to_fixed_point_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import dtfp_pkg::*;

    localparam int CHARS_PER_PHASE  = 150;
    localparam int PHASE_COUNT      = 10;
    localparam int DRAIN_CYCLES     = 40;   // covers the terminator and any padding
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 4000;

    logic clk;
    logic rst_n;
    bit   gaps_on;
    bit   long_hold_req;
    int   chars_sent;
    int   idle_cycles;
    int   fail_count;
    int   pending_count;

    dtfp_char_if   chars_if ();
    dtfp_cfg_if    cfg_if ();
    dtfp_result_if res_if ();

    decimal_text_to_fixed_point_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .cfg     (cfg_if),
        .results (res_if)
    );

    decimal_parse_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .chars         (chars_if),
        .cfg           (cfg_if),
        .results       (res_if),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold_req = 1'b0;
                res_if.ready <= 1'b1;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(0, 17)) @(negedge clk);
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (chars_if.valid && chars_if.ready) ||
            (res_if.valid && res_if.ready) || (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // called and returns at a falling edge; valid stays high for the next character
    task automatic send_char(input logic [CHAR_W-1:0] c);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            chars_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        chars_if.valid     <= 1'b1;
        chars_if.char_code <= c;
        do @(posedge clk); while (!chars_if.ready);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
        send_char(CH_NUL);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [PLACES_W-1:0] places, input logic frac,
                                  input logic sgn, input logic [RWIDTH_W-1:0] width,
                                  input logic whole);
        write_reg(CFG_FRACTION_PLACES, CFG_DATA_W'(places));
        write_reg(CFG_FRACTION_ENABLE, CFG_DATA_W'(frac));
        write_reg(CFG_SIGNED_MODE, CFG_DATA_W'(sgn));
        write_reg(CFG_RESULT_WIDTH, CFG_DATA_W'(width));
        write_reg(CFG_WHOLE_STRING_ONLY, CFG_DATA_W'(whole));
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [CHAR_W-1:0] pick_blank();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_white();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_CR;
            3: return CH_LF;
            4: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    // zeros and fives weighted up to reach the rounding corners
    function automatic logic [CHAR_W-1:0] pick_digit();
        case ($urandom_range(0, 5))
            0, 1: return CH_ZERO;
            2: return CH_FIVE;
            default: return CH_ZERO + CHAR_W'($urandom_range(0, 9));
        endcase
    endfunction

    // mostly well-formed numbers; some noise, some with one character corrupted
    task automatic send_random_string();
        logic [CHAR_W-1:0] text[$];
        int                kind;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(0, 10)) text.push_back(CHAR_W'($urandom_range(1, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 2)) text.push_back(pick_blank());
            if ($urandom_range(0, 2) == 0)
            begin
                text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
                repeat ($urandom_range(0, 1)) text.push_back(pick_blank());
            end
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(5, 21) : $urandom_range(1, 3))
                text.push_back(pick_digit());
            if ($urandom_range(0, 3) != 0)
            begin
                text.push_back(CH_POINT);
                repeat ($urandom_range(0, 8)) text.push_back(pick_digit());
            end
            case ($urandom_range(0, 5))
                0: text.push_back(pick_white());
                1: text.push_back(CHAR_W'($urandom_range(1, 255)));
                2:
                begin
                    text.push_back(pick_white());
                    text.push_back(CHAR_W'($urandom_range(1, 255)));
                end
                default: ;
            endcase
            if (kind == 1)
                text[$urandom_range(0, text.size() - 1)] = CHAR_W'($urandom_range(1, 255));
        end
        foreach (text[i])
            send_char(text[i]);
        send_char(CH_NUL);
    endtask

    initial
    begin
        int phase_start;
        rst_n              = 1'b0;
        chars_if.valid     = 1'b0;
        chars_if.char_code = CH_NUL;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = CFG_FRACTION_PLACES;
        cfg_if.data        = '0;
        gaps_on            = 1'b1;
        long_hold_req      = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: no places, fraction on, signed, 64-bit range
        send_text("\t-2.51");   // half with a later non-zero digit rounds away
        send_text("4.5");       // exact half rounds toward zero
        send_char(CH_PLUS);
        send_char(8'hFF);
        send_char(CH_NUL);
        send_text("6.6 x");
        send_char(CH_NUL);      // empty string: no digit
        chars_if.valid <= 1'b0;
        wait_drained();

        for (int phase_no = 0; phase_no < PHASE_COUNT; phase_no++)
        begin
            case (phase_no)
                0: apply_settings(5'd0, 1'b1, 1'b1, RW_64, 1'b0);
                1: apply_settings(5'd31, 1'b1, 1'b1, RW_64, 1'b0);
                2: apply_settings(5'd2, 1'b1, 1'b1, RW_8, 1'b1);
                3: apply_settings(5'd4, 1'b0, 1'b0, RW_16, 1'b0);
                4: apply_settings(5'd0, 1'b0, 1'b1, RW_32, 1'b1);
                5: apply_settings(5'd3, 1'b1, 1'b0, RW_64, 1'b1);
                6: apply_settings(5'd1, 1'b1, 1'b1, RW_8, 1'b0);
                default:
                    apply_settings(($urandom_range(0, 9) == 0) ? 5'd31 :
                                   PLACES_W'($urandom_range(0, 6)),
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                   RWIDTH_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            endcase
            if (phase_no == 3)
                long_hold_req = 1'b1;
            if (phase_no == PHASE_COUNT - 1)
                gaps_on = 1'b0;
            phase_start = chars_sent;
            while (chars_sent < phase_start + CHARS_PER_PHASE)
                send_random_string();
            chars_if.valid <= 1'b0;
            wait_drained();
        end

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
rtl/dtfp_pkg.sv
rtl/dtfp_char_if.sv
rtl/dtfp_cfg_if.sv
rtl/dtfp_result_if.sv
rtl/dtfp_ctrl.sv
rtl/dtfp_dp.sv
rtl/decimal_text_to_fixed_point_unit.sv
tb/sv/decimal_parse_checker.sv
tb/sv/tb_decimal_text_to_fixed_point_unit.sv
